/* sv/fsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan speed controller package
// Widths, filter coefficients, register map, reset values and sequencer states.
// ----------------------------------------------------------------------------
package fsc_pkg;

    localparam int TEMP_W   = 19;   // signed millidegrees
    localparam int LVL_W    = 12;   // fan level
    localparam int DB_W     = 8;    // deadband width
    localparam int COEF_W   = 16;   // filter coefficient width, also the fraction of 1.0

    localparam logic [COEF_W-1:0] COEF_KEEP = 16'd58982;
    localparam logic [COEF_W-1:0] COEF_NEW  = 16'd6554;

    localparam int DECIMATION_DEF = 4;
    localparam int FRAC_BITS_DEF  = 16;

    // ramp arithmetic: (f - off) is non-negative there and below 2^20
    localparam int DIFF_W = TEMP_W + 1;
    localparam int NUM_W  = DIFF_W + LVL_W;
    localparam int DIV_W  = TEMP_W;     // high - off is below 2^19

    // configuration port
    localparam int REG_NUM = 8;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // stream payload
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_USED_W  = LVL_W + 3 + TEMP_W;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [2:0] {
        REG_ON_TEMP,
        REG_OFF_TEMP,
        REG_HIGH_TEMP,
        REG_MIN_FAN,
        REG_KICK_FAN,
        REG_MAX_FAN,
        REG_UP_DB,
        REG_DOWN_DB
    } t_reg_idx;

    localparam logic signed [TEMP_W-1:0] ON_TEMP_RST   = 19'sd65000;
    localparam logic signed [TEMP_W-1:0] OFF_TEMP_RST  = 19'sd60000;
    localparam logic signed [TEMP_W-1:0] HIGH_TEMP_RST = 19'sd80000;
    localparam logic [LVL_W-1:0]         MIN_FAN_RST   = 12'd150;
    localparam logic [LVL_W-1:0]         KICK_FAN_RST  = 12'd200;
    localparam logic [LVL_W-1:0]         MAX_FAN_RST   = 12'd480;
    localparam logic [DB_W-1:0]          UP_DB_RST     = 8'd5;
    localparam logic [DB_W-1:0]          DOWN_DB_RST   = 8'd10;
    localparam int                       FILT_RST_INT  = 25000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILT,
        S_UPD,
        S_CTRL,
        S_DIV,
        S_RAMP,
        S_APPLY,
        S_DONE
    } t_state;

endpackage

/* sv/fan_speed_controller_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan speed controller
// Smoothed temperature, on/off hysteresis and a linear ramp with deadbands.
// ----------------------------------------------------------------------------
// Usage:
//   Each input transaction on the s-channel carries one temperature sample in
//   signed millidegrees. Every sample produces exactly one output transaction
//   on the m-channel: applied level, fan state, level-changed flag, control
//   tick flag and the integer part of the smoothed temperature.
//   One shared adder runs the filter and the ramp divide under a small
//   sequencer: a bit-serial shift-add for the filter, then the control step.
//   A small multiplier forms the ramp numerator, and the divide for the ramp
//   runs 32 restoring steps on the shared adder. A kick, a stop or a flat
//   ramp level is checked, and the ramp divide runs, only on every
//   DECIMATION-th sample, and only when the control step calls for it.
//   The block is ready for the next sample once the result is registered.
//   s_tready is low while a sample is being worked on. The result sits in
//   an output register; the block takes the next sample while it waits. If
//   the receiver still stalls when the next result is done, the sequencer
//   holds that result until the register frees. Synchronous reset restores the
//   register defaults, sets the smoothed temperature to 25000 millidegrees,
//   turns the fan off at level 0 and clears the sample counter. Write
//   configuration only while idle.
// ----------------------------------------------------------------------------
module fan_speed_controller_top #(
    parameter int DECIMATION = fsc_pkg::DECIMATION_DEF,
    parameter int FRAC_BITS  = fsc_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fsc_pkg::ADDR_W-1:0]         paddr,
    input  logic [fsc_pkg::DATA_W-1:0]         pwdata,
    output logic [fsc_pkg::DATA_W-1:0]         prdata,
    output logic                               pready,
    // sample input
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [fsc_pkg::IN_TDATA_W-1:0]     i_s_tdata,   // [18:0] temp_sample
    // result output
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [11:0] duty_level, [12] fan_running, [13] level_changed,
    // [14] control_tick, [33:15] smoothed_temp
    output logic [fsc_pkg::OUT_TDATA_W-1:0]    o_m_tdata
);
    import fsc_pkg::*;

    localparam int FW         = FRAC_BITS + TEMP_W + 1;   // filter state width
    localparam int AW         = FW + COEF_W + 1;          // shared adder width
    localparam int FI_W       = TEMP_W + 1;               // integer part of filter
    localparam int LX         = NUM_W + 3;                // signed ramp level
    localparam int COEF_IDX_W = $clog2(COEF_W);
    localparam int STEPS_MAX  = (NUM_W > 2 * COEF_W) ? NUM_W : 2 * COEF_W;
    localparam int STEP_W     = $clog2(STEPS_MAX);
    localparam int SMP_W      = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
    localparam logic [FW-1:0] FILT_RST = FW'(FILT_RST_INT) << FRAC_BITS;

    // configuration registers
    logic signed [TEMP_W-1:0] r_on_temp;
    logic signed [TEMP_W-1:0] r_off_temp;
    logic signed [TEMP_W-1:0] r_high_temp;
    logic [LVL_W-1:0]         r_min_fan;
    logic [LVL_W-1:0]         r_kick_fan;
    logic [LVL_W-1:0]         r_max_fan;
    logic [DB_W-1:0]          r_up_db;
    logic [DB_W-1:0]          r_down_db;

    // control state
    t_state              r_state, n_state;
    logic [FW-1:0]       r_f;
    logic                r_fan_on;
    logic [LVL_W-1:0]    r_app;
    logic [SMP_W-1:0]    r_smp;
    logic [STEP_W-1:0]   r_step;
    logic                r_tick;
    logic                r_changed;
    logic                r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    // datapath registers
    logic [TEMP_W-1:0]   r_t;
    logic [AW-1:0]       r_acc;
    logic [AW-1:0]       r_opnd;
    logic [NUM_W-1:0]    r_num;       // dividend, shifts into quotient
    logic [DIV_W-1:0]    r_rem;
    logic [DIV_W-1:0]    r_div;
    logic                r_neg;
    logic [LVL_W-1:0]    r_req;

    // ------------------------------------------------------------------
    // Configuration port: no wait states
    // ------------------------------------------------------------------
    t_reg_idx reg_idx;
    logic     cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_temp   <= ON_TEMP_RST;
            r_off_temp  <= OFF_TEMP_RST;
            r_high_temp <= HIGH_TEMP_RST;
            r_min_fan   <= MIN_FAN_RST;
            r_kick_fan  <= KICK_FAN_RST;
            r_max_fan   <= MAX_FAN_RST;
            r_up_db     <= UP_DB_RST;
            r_down_db   <= DOWN_DB_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_ON_TEMP:   r_on_temp   <= pwdata[TEMP_W-1:0];
                REG_OFF_TEMP:  r_off_temp  <= pwdata[TEMP_W-1:0];
                REG_HIGH_TEMP: r_high_temp <= pwdata[TEMP_W-1:0];
                REG_MIN_FAN:   r_min_fan   <= pwdata[LVL_W-1:0];
                REG_KICK_FAN:  r_kick_fan  <= pwdata[LVL_W-1:0];
                REG_MAX_FAN:   r_max_fan   <= pwdata[LVL_W-1:0];
                REG_UP_DB:     r_up_db     <= pwdata[DB_W-1:0];
                REG_DOWN_DB:   r_down_db   <= pwdata[DB_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ON_TEMP:   prdata = {{(DATA_W-TEMP_W){r_on_temp[TEMP_W-1]}}, r_on_temp};
            REG_OFF_TEMP:  prdata = {{(DATA_W-TEMP_W){r_off_temp[TEMP_W-1]}}, r_off_temp};
            REG_HIGH_TEMP: prdata = {{(DATA_W-TEMP_W){r_high_temp[TEMP_W-1]}}, r_high_temp};
            REG_MIN_FAN:   prdata = {{(DATA_W-LVL_W){1'b0}}, r_min_fan};
            REG_KICK_FAN:  prdata = {{(DATA_W-LVL_W){1'b0}}, r_kick_fan};
            REG_MAX_FAN:   prdata = {{(DATA_W-LVL_W){1'b0}}, r_max_fan};
            REG_UP_DB:     prdata = {{(DATA_W-DB_W){1'b0}}, r_up_db};
            REG_DOWN_DB:   prdata = {{(DATA_W-DB_W){1'b0}}, r_down_db};
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Shared adder: filter shift-add and restoring divide both run here
    // ------------------------------------------------------------------
    logic [AW-1:0] u_a, u_b, u_sum;
    logic          u_sub;

    assign u_sum = u_a + (u_sub ? ~u_b : u_b) + AW'(u_sub);

    // filter step: phase 0 walks the keep coefficient over f,
    // phase 1 walks the new-sample coefficient over t << FRAC_BITS
    logic                  filt_phase;
    logic [COEF_IDX_W-1:0] coef_idx;
    logic                  coef_bit;
    logic [AW-1:0]         t_scaled;
    logic                  div_neg;

    assign filt_phase = r_step[COEF_IDX_W];
    assign coef_idx   = r_step[COEF_IDX_W-1:0];
    assign coef_bit   = filt_phase ? COEF_NEW[coef_idx] : COEF_KEEP[coef_idx];
    assign t_scaled   = {{(AW-TEMP_W){r_t[TEMP_W-1]}}, r_t} << FRAC_BITS;
    assign div_neg    = u_sum[AW-1];

    always_comb begin
        u_a   = '0;
        u_b   = '0;
        u_sub = 1'b0;
        case (r_state)
            S_FILT: begin
                u_a = r_acc;
                u_b = coef_bit ? r_opnd : '0;
            end
            S_DIV: begin
                // trial subtract of the divisor from the shifted remainder
                u_a   = {{(AW-DIV_W-1){1'b0}}, r_rem, r_num[NUM_W-1]};
                u_b   = {{(AW-DIV_W){1'b0}}, r_div};
                u_sub = 1'b1;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Control step decode
    // ------------------------------------------------------------------
    logic signed [FI_W-1:0] fi;
    logic signed [FI_W-1:0] on_ext, off_ext, high_ext;
    logic signed [FI_W:0]   diff_full;
    logic signed [FI_W-1:0] span;
    logic [DIFF_W-1:0]      ramp_diff;
    logic signed [LVL_W:0]  mdiff;
    logic [LVL_W:0]         mdiff_inv;
    logic                   mneg;
    logic [LVL_W-1:0]       mmag;
    logic [NUM_W-1:0]       prod;
    logic                   tick;
    logic                   go_on, go_off, ramp_flat;

    assign fi        = r_f[FW-1 -: FI_W];
    assign on_ext    = {r_on_temp[TEMP_W-1], r_on_temp};
    assign off_ext   = {r_off_temp[TEMP_W-1], r_off_temp};
    assign high_ext  = {r_high_temp[TEMP_W-1], r_high_temp};
    assign diff_full = {fi[FI_W-1], fi} - {off_ext[FI_W-1], off_ext};
    assign ramp_diff = diff_full[DIFF_W-1:0];    // f >= off on the ramp path
    assign span      = high_ext - off_ext;
    assign mdiff     = {1'b0, r_max_fan} - {1'b0, r_min_fan};
    assign mdiff_inv = -mdiff;
    assign mneg      = mdiff[LVL_W];
    assign mmag      = mneg ? mdiff_inv[LVL_W-1:0] : mdiff[LVL_W-1:0];
    assign prod      = NUM_W'(ramp_diff) * NUM_W'(mmag);
    assign tick      = (r_smp == SMP_W'(DECIMATION - 1));
    assign go_on     = !r_fan_on && (fi > on_ext);
    assign go_off    = r_fan_on && (fi < off_ext);
    assign ramp_flat = (r_high_temp <= r_off_temp);

    // ramp level with floor, then clamp to 0..max_fan
    logic signed [LX-1:0] q_mag, q_sgn, lvl, max_ext;
    logic [LVL_W-1:0]     lvl_clamp;

    assign q_mag   = {{(LX-NUM_W){1'b0}}, r_num};
    assign q_sgn   = r_neg ? (-q_mag - LX'(r_rem != '0)) : q_mag;
    assign lvl     = {{(LX-LVL_W){1'b0}}, r_min_fan} + q_sgn;
    assign max_ext = {{(LX-LVL_W){1'b0}}, r_max_fan};

    always_comb begin
        if (lvl[LX-1]) begin
            lvl_clamp = '0;
        end else if (lvl > max_ext) begin
            lvl_clamp = r_max_fan;
        end else begin
            lvl_clamp = lvl[LVL_W-1:0];
        end
    end

    // deadband check against the applied level
    logic [LVL_W:0] rise, fall, up_ext, dn_ext;
    logic           take_new;

    assign rise     = {1'b0, r_req} - {1'b0, r_app};
    assign fall     = {1'b0, r_app} - {1'b0, r_req};
    assign up_ext   = {{(LVL_W+1-DB_W){1'b0}}, r_up_db};
    assign dn_ext   = {{(LVL_W+1-DB_W){1'b0}}, r_down_db};
    assign take_new = ((r_req > r_app) && (rise >= up_ext)) ||
                      ((r_req < r_app) && (fall >= dn_ext));

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic s_acc;
    logic out_free;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (s_acc) n_state = S_FILT;
            S_FILT:  if (r_step == STEP_W'(2 * COEF_W - 1)) n_state = S_UPD;
            S_UPD:   n_state = S_CTRL;
            S_CTRL: begin
                if (tick && (go_on || go_off)) begin
                    n_state = S_APPLY;
                end else if (tick && r_fan_on) begin
                    n_state = ramp_flat ? S_APPLY : S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV:   if (r_step == STEP_W'(NUM_W - 1)) n_state = S_RAMP;
            S_RAMP:  n_state = S_APPLY;
            S_APPLY: n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f         <= FILT_RST;
            r_fan_on    <= 1'b0;
            r_app       <= '0;
            r_smp       <= '0;
            r_step      <= '0;
            r_tick      <= 1'b0;
            r_changed   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: r_step <= '0;
                S_FILT: r_step <= r_step + STEP_W'(1);
                S_UPD: begin
                    // drop the 16 coefficient fraction bits (floor)
                    r_f <= r_acc[COEF_W +: FW];
                end
                S_CTRL: begin
                    r_step    <= '0;
                    r_tick    <= tick;
                    r_changed <= 1'b0;
                    r_smp     <= tick ? '0 : r_smp + SMP_W'(1);
                    if (tick && go_on) begin
                        r_fan_on <= 1'b1;
                    end else if (tick && go_off) begin
                        r_fan_on <= 1'b0;
                    end
                end
                S_DIV: r_step <= r_step + STEP_W'(1);
                S_APPLY: begin
                    if (take_new) begin
                        r_app     <= r_req;
                        r_changed <= 1'b1;
                    end
                end
                default: ;
            endcase

            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    r_t    <= i_s_tdata[TEMP_W-1:0];
                    r_acc  <= '0;
                    r_opnd <= {{(AW-FW){r_f[FW-1]}}, r_f};
                end
            end
            S_FILT: begin
                r_acc <= u_sum;
                // switch to the sample term after the last keep bit
                if (!filt_phase && coef_idx == COEF_IDX_W'(COEF_W - 1)) begin
                    r_opnd <= t_scaled;
                end else begin
                    r_opnd <= r_opnd << 1;
                end
            end
            S_CTRL: begin
                r_rem <= '0;
                r_num <= prod;
                r_neg <= mneg;
                r_div <= span[DIV_W-1:0];
                if (go_on) begin
                    r_req <= r_kick_fan;
                end else if (go_off) begin
                    r_req <= '0;
                end else begin
                    r_req <= r_max_fan;
                end
            end
            S_DIV: begin
                r_num <= {r_num[NUM_W-2:0], !div_neg};
                if (div_neg) begin
                    r_rem <= {r_rem[DIV_W-2:0], r_num[NUM_W-1]};
                end else begin
                    r_rem <= u_sum[DIV_W-1:0];
                end
            end
            S_RAMP: r_req <= lvl_clamp;
            S_DONE: begin
                if (out_free) begin
                    r_out_data <= {{(OUT_TDATA_W-OUT_USED_W){1'b0}},
                                   fi[TEMP_W-1:0], r_tick, r_changed, r_fan_on, r_app};
                end
            end
            default: ;
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

`ifndef SYNTHESIS
    // one sample in flight: ready drops right after an accepted transaction
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("sample accepted while another is in flight");

    // a level change happens only on a control tick
    a_change_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (!o_m_tdata[LVL_W+1] || o_m_tdata[LVL_W+2]))
        else $error("level change without control tick");

    // a change that leaves the fan off can only be the stop to level 0
    a_stop_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[LVL_W+1] && !o_m_tdata[LVL_W]) |->
        (o_m_tdata[LVL_W-1:0] == '0))
        else $error("fan stopped with nonzero applied level");

    // divide only runs with a positive span
    a_div_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_div != '0))
        else $error("ramp divide with zero divisor");

    a_smp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_smp) < DECIMATION))
        else $error("sample counter out of range");
`endif

endmodule

/* dv/fan_status_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan status checker
// Snoops the register port and both streams, keeps its own model of the
// filter, hysteresis, ramp and deadbands, and compares every result.
// ----------------------------------------------------------------------------
module fan_status_checker
    import fsc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_psel,
    input  logic                   i_penable,
    input  logic                   i_pwrite,
    input  logic                   i_pready,
    input  logic [ADDR_W-1:0]      i_paddr,
    input  logic [DATA_W-1:0]      i_pwdata,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,
    output int                     o_pending,
    output int                     o_mismatches,
    output int                     o_checked,
    output int                     o_ticks,
    output int                     o_changes
);

    typedef struct {
        logic [LVL_W-1:0]  duty;
        logic              running;
        logic              changed;
        logic              tick;
        logic [TEMP_W-1:0] smoothed;
    } t_fan_status;

    // thresholds and levels as the block holds them, widened
    longint on_lim, off_lim, high_lim;
    longint min_lvl, kick_lvl, max_lvl, up_db, down_db;

    // controller state
    longint filt_acc;
    bit     fan_on;
    longint level_now;
    int     decim_cnt;

    t_fan_status fan_status_q[$];

    function automatic longint floor_quot(longint num, longint den);
        longint q;
        q = num / den;
        if ((num % den != 0) && ((num < 0) != (den < 0)))
            q -= 1;
        return q;
    endfunction

    // apply a requested level unless the deadband swallows it
    function automatic bit take_level(longint want);
        if (want > level_now && want - level_now < up_db)
            return 1'b0;
        if (want < level_now && level_now - want < down_db)
            return 1'b0;
        if (want == level_now)
            return 1'b0;
        level_now = want;
        return 1'b1;
    endfunction

    function automatic t_fan_status advance_fan_model(logic signed [TEMP_W-1:0] temp_in);
        longint      one_lsb;
        longint      mix;
        longint      temp_int;
        longint      ramp;
        bit          tick;
        bit          moved;
        t_fan_status st;
        one_lsb  = longint'(1) <<< FRAC_BITS_DEF;
        mix      = longint'(COEF_KEEP) * filt_acc
                 + longint'(COEF_NEW) * (longint'(temp_in) * one_lsb);
        filt_acc = floor_quot(mix, longint'(1) <<< COEF_W);
        temp_int = floor_quot(filt_acc, one_lsb);
        tick     = 1'b0;
        moved    = 1'b0;
        decim_cnt++;
        if (decim_cnt >= DECIMATION_DEF) begin
            decim_cnt = 0;
            tick      = 1'b1;
        end
        if (tick) begin
            if (!fan_on && temp_int > on_lim) begin
                moved  = take_level(kick_lvl);
                fan_on = 1'b1;
            end else if (fan_on && temp_int < off_lim) begin
                moved  = take_level(0);
                fan_on = 1'b0;
            end else if (fan_on) begin
                if (high_lim <= off_lim)
                    ramp = max_lvl;
                else
                    ramp = min_lvl + floor_quot((temp_int - off_lim) * (max_lvl - min_lvl),
                                                high_lim - off_lim);
                if (ramp < 0)
                    ramp = 0;
                if (ramp > max_lvl)
                    ramp = max_lvl;
                moved = take_level(ramp);
            end
        end
        st.duty     = level_now[LVL_W-1:0];
        st.running  = fan_on;
        st.changed  = moved;
        st.tick     = tick;
        st.smoothed = temp_int[TEMP_W-1:0];
        return st;
    endfunction

    task automatic note_mismatch(input string what, input logic [39:0] exp_v,
                                 input logic [39:0] act_v);
        o_mismatches++;
        if (o_mismatches <= 10)
            $display("MISMATCH %0t: %s expected %h got %h", $time, what, exp_v, act_v);
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_fan_status want_st;
        t_fan_status got_st;
        int          pushed;
        int          popped;
        if (!i_rst_n) begin
            on_lim    = longint'(ON_TEMP_RST);
            off_lim   = longint'(OFF_TEMP_RST);
            high_lim  = longint'(HIGH_TEMP_RST);
            min_lvl   = longint'(MIN_FAN_RST);
            kick_lvl  = longint'(KICK_FAN_RST);
            max_lvl   = longint'(MAX_FAN_RST);
            up_db     = longint'(UP_DB_RST);
            down_db   = longint'(DOWN_DB_RST);
            filt_acc  = longint'(FILT_RST_INT) <<< FRAC_BITS_DEF;
            fan_on    = 1'b0;
            level_now = 0;
            decim_cnt = 0;
            fan_status_q.delete();
            o_pending <= 0;
        end else begin
            pushed = 0;
            popped = 0;
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[ADDR_W-1:2]))
                    REG_ON_TEMP:   on_lim   = longint'($signed(i_pwdata[TEMP_W-1:0]));
                    REG_OFF_TEMP:  off_lim  = longint'($signed(i_pwdata[TEMP_W-1:0]));
                    REG_HIGH_TEMP: high_lim = longint'($signed(i_pwdata[TEMP_W-1:0]));
                    REG_MIN_FAN:   min_lvl  = longint'(i_pwdata[LVL_W-1:0]);
                    REG_KICK_FAN:  kick_lvl = longint'(i_pwdata[LVL_W-1:0]);
                    REG_MAX_FAN:   max_lvl  = longint'(i_pwdata[LVL_W-1:0]);
                    REG_UP_DB:     up_db    = longint'(i_pwdata[DB_W-1:0]);
                    REG_DOWN_DB:   down_db  = longint'(i_pwdata[DB_W-1:0]);
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                fan_status_q.push_back(advance_fan_model(i_s_tdata[TEMP_W-1:0]));
                pushed = 1;
            end
            if (i_m_tvalid && i_m_tready) begin
                got_st.duty     = i_m_tdata[LVL_W-1:0];
                got_st.running  = i_m_tdata[LVL_W];
                got_st.changed  = i_m_tdata[LVL_W+1];
                got_st.tick     = i_m_tdata[LVL_W+2];
                got_st.smoothed = i_m_tdata[LVL_W+3 +: TEMP_W];
                if (fan_status_q.size() == 0) begin
                    note_mismatch("result with nothing outstanding", '0, 40'(i_m_tdata));
                end else begin
                    want_st = fan_status_q.pop_front();
                    popped  = 1;
                    o_checked++;
                    if (want_st.tick)
                        o_ticks++;
                    if (want_st.changed)
                        o_changes++;
                    if (got_st.duty !== want_st.duty)
                        note_mismatch("duty_level", 40'(want_st.duty), 40'(got_st.duty));
                    if (got_st.running !== want_st.running)
                        note_mismatch("fan_running", 40'(want_st.running),
                                      40'(got_st.running));
                    if (got_st.changed !== want_st.changed)
                        note_mismatch("level_changed", 40'(want_st.changed),
                                      40'(got_st.changed));
                    if (got_st.tick !== want_st.tick)
                        note_mismatch("control_tick", 40'(want_st.tick), 40'(got_st.tick));
                    if (got_st.smoothed !== want_st.smoothed)
                        note_mismatch("smoothed_temp", 40'(want_st.smoothed),
                                      40'(got_st.smoothed));
                end
            end
            o_pending <= o_pending + pushed - popped;
        end
    end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan speed controller testbench
// Drives temperature samples and register settings into the controller, with
// random stalls on both streams; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
    import fsc_pkg::*;

    // register setting profiles used between sample bursts
    typedef enum int {
        CFG_RESET_VALUES,
        CFG_RANDOM,
        CFG_WIDE_EXTREME,
        CFG_LOW_EXTREME,
        CFG_FLAT_RAMP,
        CFG_FALLING_RAMP,
        CFG_STIFF_DEADBAND,
        CFG_NO_DEADBAND,
        CFG_RAW_BITS,
        CFG_COUNT
    } t_cfg_profile;

    localparam int SAMPLE_TARGET = 1450;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 100;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   psel       = 1'b0;
    logic                   penable    = 1'b0;
    logic                   pwrite     = 1'b0;
    logic [ADDR_W-1:0]      paddr      = '0;
    logic [DATA_W-1:0]      pwdata     = '0;
    logic [DATA_W-1:0]      prdata;
    logic                   pready;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata  = '0;   // [18:0] temp_sample
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    // [11:0] duty_level, [12] fan_running, [13] level_changed,
    // [14] control_tick, [33:15] smoothed_temp
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    int pending_cnt, mismatch_cnt, checked_cnt, tick_cnt, change_cnt;

    // stimulus bookkeeping
    int sent_cnt     = 0;
    int setting_cnt  = 0;
    bit burst_mode   = 1'b0;     // no idling on either side while set
    int sink_hold    = 0;
    int sink_roll    = 0;
    int on_set       = 65000;
    int off_set      = 60000;
    int high_set     = 80000;

    always #5 i_clk = ~i_clk;

    fan_speed_controller_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    fan_status_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .o_pending    (pending_cnt),
        .o_mismatches (mismatch_cnt),
        .o_checked    (checked_cnt),
        .o_ticks      (tick_cnt),
        .o_changes    (change_cnt)
    );

    // Receiver pacing: mostly ready, short stalls now and then, rare long ones.
    // Hold ready high for the whole burst while burst_mode is set.
    always @(posedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold--;
            i_m_tready <= 1'b0;
        end else if (burst_mode) begin
            i_m_tready <= 1'b1;
        end else begin
            sink_roll = $urandom_range(99);
            if (sink_roll < 3) begin
                sink_hold = $urandom_range(200, 30);
                i_m_tready <= 1'b0;
            end else if (sink_roll < 25) begin
                sink_hold = $urandom_range(3);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Saturate to the 19-bit sample field.
    function automatic logic [TEMP_W-1:0] clip_temp(int v);
        if (v > 262143)
            v = 262143;
        if (v < -262144)
            v = -262144;
        return TEMP_W'(v);
    endfunction

    function automatic int rand_temp();
        return int'($urandom_range(190000)) - 40000;
    endfunction

    // Offer one sample and hold it until the block takes it, then maybe idle.
    task automatic push_sample(input logic [TEMP_W-1:0] temp_bits);
        int gap;
        int roll;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= IN_TDATA_W'(temp_bits);
        do @(posedge i_clk); while (!o_s_tready);
        sent_cnt++;
        gap  = 0;
        roll = $urandom_range(99);
        if (!burst_mode) begin
            if (roll < 3)
                gap = $urandom_range(150, 30);
            else if (roll < 30)
                gap = $urandom_range(4, 1);
        end
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid and hold off until every outstanding result is back.
    // Wait one edge first so the checker's count includes the last transaction.
    task automatic wait_drained();
        int guard;
        guard = 0;
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    // One write: setup cycle, then access until pready.
    task automatic write_reg(input t_reg_idx idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    // Write all eight registers for one profile; block must be idle.
    task automatic program_thresholds(input t_cfg_profile profile);
        logic [DATA_W-1:0] val [REG_NUM];
        int                base;
        int                lvl;
        base = rand_temp();
        val[REG_ON_TEMP]   = DATA_W'(base + int'($urandom_range(15000)));
        val[REG_OFF_TEMP]  = DATA_W'(base);
        val[REG_HIGH_TEMP] = DATA_W'(base + int'($urandom_range(60000, 1000)));
        lvl                = $urandom_range(2000);
        val[REG_MIN_FAN]   = DATA_W'(lvl);
        val[REG_MAX_FAN]   = DATA_W'(lvl + int'($urandom_range(4095 - lvl)));
        val[REG_KICK_FAN]  = DATA_W'($urandom_range(4095));
        val[REG_UP_DB]     = DATA_W'($urandom_range(40));
        val[REG_DOWN_DB]   = DATA_W'($urandom_range(40));
        case (profile)
            CFG_RESET_VALUES: begin
                val[REG_ON_TEMP]   = DATA_W'(ON_TEMP_RST);
                val[REG_OFF_TEMP]  = DATA_W'(OFF_TEMP_RST);
                val[REG_HIGH_TEMP] = DATA_W'(HIGH_TEMP_RST);
                val[REG_MIN_FAN]   = DATA_W'(MIN_FAN_RST);
                val[REG_KICK_FAN]  = DATA_W'(KICK_FAN_RST);
                val[REG_MAX_FAN]   = DATA_W'(MAX_FAN_RST);
                val[REG_UP_DB]     = DATA_W'(UP_DB_RST);
                val[REG_DOWN_DB]   = DATA_W'(DOWN_DB_RST);
            end
            CFG_WIDE_EXTREME: begin
                val[REG_ON_TEMP]   = DATA_W'(150000);
                val[REG_OFF_TEMP]  = DATA_W'(-40000);
                val[REG_HIGH_TEMP] = DATA_W'(150000);
                val[REG_MIN_FAN]   = DATA_W'(0);
                val[REG_KICK_FAN]  = DATA_W'(4095);
                val[REG_MAX_FAN]   = DATA_W'(4095);
                val[REG_UP_DB]     = DATA_W'(255);
                val[REG_DOWN_DB]   = DATA_W'(255);
            end
            CFG_LOW_EXTREME: begin
                val[REG_ON_TEMP]   = DATA_W'(-40000);
                val[REG_OFF_TEMP]  = DATA_W'(-40000);
                val[REG_HIGH_TEMP] = DATA_W'(-40000);
                val[REG_MIN_FAN]   = DATA_W'(4095);
                val[REG_KICK_FAN]  = DATA_W'(0);
                val[REG_MAX_FAN]   = DATA_W'(0);
                val[REG_UP_DB]     = DATA_W'(0);
                val[REG_DOWN_DB]   = DATA_W'(0);
            end
            CFG_FLAT_RAMP: begin
                // high at or below off: the ramp collapses to max_fan
                val[REG_HIGH_TEMP] = DATA_W'(base - int'($urandom_range(20000)));
            end
            CFG_FALLING_RAMP: begin
                // max below min: the ramp slopes down and can go below zero
                lvl               = $urandom_range(4095, 1000);
                val[REG_MIN_FAN]  = DATA_W'(lvl);
                val[REG_MAX_FAN]  = DATA_W'($urandom_range(lvl - 1));
                val[REG_HIGH_TEMP] = DATA_W'(base + int'($urandom_range(8000, 1000)));
            end
            CFG_STIFF_DEADBAND: begin
                // small kick against a wide band: start and stop can get rejected
                val[REG_KICK_FAN] = DATA_W'($urandom_range(200));
                val[REG_UP_DB]    = DATA_W'($urandom_range(255, 100));
                val[REG_DOWN_DB]  = DATA_W'($urandom_range(255, 100));
            end
            CFG_NO_DEADBAND: begin
                val[REG_UP_DB]   = DATA_W'(0);
                val[REG_DOWN_DB] = DATA_W'(0);
            end
            CFG_RAW_BITS: begin
                // arbitrary bit patterns, upper bus bits included
                foreach (val[i])
                    val[i] = $urandom();
            end
            default: ;
        endcase
        for (int i = 0; i < REG_NUM; i++)
            write_reg(t_reg_idx'(i), val[i]);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        on_set   = int'($signed(val[REG_ON_TEMP][TEMP_W-1:0]));
        off_set  = int'($signed(val[REG_OFF_TEMP][TEMP_W-1:0]));
        high_set = int'($signed(val[REG_HIGH_TEMP][TEMP_W-1:0]));
        setting_cnt++;
        @(posedge i_clk);
    endtask

    // One burst of samples: segments that sit below, inside and above the
    // hysteresis window, so the filter really crosses the thresholds, with
    // some raw noise and field extremes mixed in.
    task automatic run_burst(input int n_items);
        int seg_left;
        int target;
        int roll;
        int bot_t;
        int top_t;
        int swap_t;
        logic [TEMP_W-1:0] temp_bits;
        seg_left = 0;
        target   = 0;
        bot_t    = off_set;
        top_t    = (on_set > high_set) ? on_set : high_set;
        if (top_t < bot_t) begin
            swap_t = top_t;
            top_t  = bot_t;
            bot_t  = swap_t;
        end
        for (int n = 0; n < n_items; n++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(30, 6);
                case ($urandom_range(2))
                    0:       target = bot_t - int'($urandom_range(40000, 1000));
                    1:       target = bot_t + int'($urandom_range(top_t - bot_t));
                    default: target = top_t + int'($urandom_range(60000, 1000));
                endcase
            end
            seg_left--;
            roll = $urandom_range(99);
            if (roll < 8) begin
                temp_bits = TEMP_W'($urandom());
            end else if (roll < 10) begin
                case ($urandom_range(3))
                    0:       temp_bits = '0;
                    1:       temp_bits = '1;
                    2:       temp_bits = clip_temp(262143);
                    default: temp_bits = clip_temp(-262144);
                endcase
            end else begin
                temp_bits = clip_temp(target + int'($urandom_range(5000)) - 2500);
            end
            push_sample(temp_bits);
            // now and then let the pipeline run dry mid-burst
            if ($urandom_range(99) < 2)
                wait_drained();
        end
    endtask

    initial begin
        t_cfg_profile profile;
        int           k;
        // hold reset, then release
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed start at reset settings: field extremes and all-zero /
        // all-one patterns, then a hot stretch to start the fan, a moderate
        // one on the ramp, and a cold one to stop it.
        for (int n = 0; n < 25; n++) begin
            if (n == 0)
                push_sample('0);
            else if (n == 1)
                push_sample('1);
            else if (n == 2)
                push_sample(clip_temp(262143));
            else if (n == 3)
                push_sample(clip_temp(-262144));
            else if (n == 4)
                push_sample(clip_temp(-40000));
            else if (n < 17)
                push_sample(clip_temp(150000));
            else if (n < 21)
                push_sample(clip_temp(70000));
            else
                push_sample(clip_temp(-40000));
        end

        // visit every profile once, then mostly random settings
        k = 0;
        while (sent_cnt < SAMPLE_TARGET) begin
            wait_drained();
            if (k < int'(CFG_COUNT))
                profile = t_cfg_profile'(k);
            else if ($urandom_range(1) == 0)
                profile = CFG_RANDOM;
            else
                profile = t_cfg_profile'($urandom_range(int'(CFG_COUNT) - 1));
            k++;
            burst_mode = ($urandom_range(4) == 0);
            program_thresholds(profile);
            run_burst($urandom_range(80, 30));
        end

        // let everything come back, then settle
        burst_mode = 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d samples under %0d register settings, %0d results checked.",
                 sent_cnt, setting_cnt, checked_cnt);
        $display("Results included %0d control steps and %0d applied level changes.",
                 tick_cnt, change_cnt);
        if (mismatch_cnt == 0 && pending_cnt == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin
        #40_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
